// ----- rtl/gmsu_pkg.sv -----
// Shared types, codes and constants for the gene mutation store with undo.
// Depends on nothing; the controller, the datapath and the top level import it.
package gmsu_pkg;

    localparam int GENE_COUNT_DEF    = 1024;
    localparam int JOURNAL_DEPTH_DEF = 16;

    localparam logic [10:0] ACTIVE_SIZE_RST = 11'd1024;

    // request codes
    localparam logic [2:0] REQ_LOAD    = 3'd0;
    localparam logic [2:0] REQ_REPLACE = 3'd1;
    localparam logic [2:0] REQ_INVERT  = 3'd2;
    localparam logic [2:0] REQ_UNDO    = 3'd3;
    localparam logic [2:0] REQ_READ    = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [7:0] MSB_MASK = 8'b1000_0000;

    typedef struct packed {
        logic [2:0] req_type;
        logic [9:0] gene_addr;
        logic [7:0] new_value;
        logic [2:0] flip_bit;
        logic       start_batch;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_value;
        logic [1:0] status;
        logic [4:0] journal_length;
    } out_item_t;

    // what the request at the input port turns into
    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_LOAD   = 3'd1,
        ACT_READ   = 3'd2,
        ACT_MUTATE = 3'd3,
        ACT_UNDO   = 3'd4
    } act_t;

    typedef struct packed {
        logic accept;     // take the input item
        logic modify;     // write mutated byte and journal entry
        logic undo_jrd;   // fetch next journal entry, newest first
        logic undo_grd;   // fetch the byte the entry addresses
        logic undo_wr;    // write the restored byte
        logic push;       // load the output register
    } cmd_t;

    typedef struct packed {
        act_t act;
        logic undo_last;
        logic out_busy;
    } stat_t;

    // bit 0 is the most significant bit
    function automatic logic [7:0] bit_mask(input logic [2:0] bit_pos);
        bit_mask = MSB_MASK >> bit_pos;
    endfunction

endpackage

// ----- rtl/gmsu_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module gmsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/gmsu_ctrl.sv -----
// Sequencer for the gene mutation store: walks each request through its steps.
// Depends on gmsu_pkg.
module gmsu_ctrl
    import gmsu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MODIFY = 6'b000010,
        S_UNDO_J = 6'b000100,
        S_UNDO_G = 6'b001000,
        S_UNDO_W = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    case (stat.act)
                        ACT_MUTATE: state_next = S_MODIFY;
                        ACT_UNDO:   state_next = S_UNDO_J;
                        default:    state_next = S_FINISH;
                    endcase
                end
            end
            S_MODIFY:
            begin
                cmd.modify = 1'b1;
                state_next = S_FINISH;
            end
            S_UNDO_J:
            begin
                cmd.undo_jrd = 1'b1;
                state_next   = S_UNDO_G;
            end
            S_UNDO_G:
            begin
                cmd.undo_grd = 1'b1;
                state_next   = S_UNDO_W;
            end
            S_UNDO_W:
            begin
                cmd.undo_wr = 1'b1;
                state_next  = stat.undo_last ? S_FINISH : S_UNDO_J;
            end
            S_FINISH:
            begin
                // hold until the output register can take the item
                if (!stat.out_busy)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/gmsu_dpath.sv -----
// Datapath of the gene mutation store: genome RAM, journal RAM, counters,
// range checks and the output register. Depends on gmsu_pkg and gmsu_ram.
module gmsu_dpath
    import gmsu_pkg::*;
#(
    parameter int GENE_COUNT    = GENE_COUNT_DEF,
    parameter int JOURNAL_DEPTH = JOURNAL_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item,
    input  cmd_t        cmd,
    output stat_t       stat
);

    localparam int GA_W   = $clog2(GENE_COUNT);
    localparam int CMP_W  = ($clog2(GENE_COUNT + 1) > 11) ? $clog2(GENE_COUNT + 1) : 11;
    localparam int JA_W   = (JOURNAL_DEPTH > 1) ? $clog2(JOURNAL_DEPTH) : 1;
    localparam int JC_W   = $clog2(JOURNAL_DEPTH + 1);
    localparam int JE_W   = 1 + GA_W + 8;

    logic [10:0]     active_size_reg;
    logic [JC_W-1:0] count_reg;
    logic [JC_W-1:0] k_reg;
    logic [JC_W-1:0] k_m1;
    in_item_t        req_reg;
    logic [1:0]      status_reg;
    logic            rd_flag_reg;
    logic            out_valid_reg;
    out_item_t       out_item_reg;

    logic [CMP_W-1:0] idx_ext;
    logic [GA_W-1:0]  in_addr;
    logic [GA_W-1:0]  req_addr;
    logic             in_range;
    logic             is_mutate;
    logic             full;
    logic [1:0]       status_in;

    logic            g_wr_en;
    logic [GA_W-1:0] g_wr_addr;
    logic [7:0]      g_wr_data;
    logic            g_rd_en;
    logic [GA_W-1:0] g_rd_addr;
    logic [7:0]      g_rd_data;

    logic            j_wr_en;
    logic [JE_W-1:0] j_wr_data;
    logic [JE_W-1:0] j_rd_data;
    logic            e_invert;
    logic [GA_W-1:0] e_addr;
    logic [7:0]      e_info;

    // classify the request at the input port
    always_comb
    begin
        idx_ext   = CMP_W'(in_item.gene_addr);
        in_addr   = idx_ext[GA_W-1:0];
        in_range  = (idx_ext < CMP_W'(active_size_reg)) && (idx_ext < CMP_W'(GENE_COUNT));
        is_mutate = in_item.req_type inside {REQ_REPLACE, REQ_INVERT};
        full      = !in_item.start_batch && (count_reg >= JC_W'(JOURNAL_DEPTH));
        status_in = ST_OK;
        stat.act  = ACT_NONE;
        case (in_item.req_type)
            REQ_LOAD:
            begin
                status_in = in_range ? ST_OK : ST_RANGE;
                stat.act  = in_range ? ACT_LOAD : ACT_NONE;
            end
            REQ_REPLACE, REQ_INVERT:
            begin
                if (!in_range)
                begin
                    status_in = ST_RANGE;
                end
                else if (full)
                begin
                    status_in = ST_FULL;
                end
                else
                begin
                    stat.act = ACT_MUTATE;
                end
            end
            REQ_UNDO:
            begin
                stat.act = (count_reg != '0) ? ACT_UNDO : ACT_NONE;
            end
            REQ_READ:
            begin
                status_in = in_range ? ST_OK : ST_RANGE;
                stat.act  = in_range ? ACT_READ : ACT_NONE;
            end
            default:
            begin
                stat.act = ACT_NONE;
            end
        endcase
        stat.undo_last = (k_reg == '0);
        stat.out_busy  = out_valid_reg && out_stall;
    end

    assign {e_invert, e_addr, e_info} = j_rd_data;
    assign req_addr = GA_W'(CMP_W'(req_reg.gene_addr));
    assign k_m1     = k_reg - JC_W'(1);

    // genome RAM port steering
    always_comb
    begin
        g_rd_en   = (cmd.accept && (stat.act inside {ACT_READ, ACT_MUTATE}))
                    || cmd.undo_grd;
        g_rd_addr = cmd.undo_grd ? e_addr : in_addr;
        g_wr_en   = (cmd.accept && stat.act == ACT_LOAD) || cmd.modify || cmd.undo_wr;
        g_wr_addr = in_addr;
        g_wr_data = in_item.new_value;
        if (cmd.modify)
        begin
            g_wr_addr = req_addr;
            g_wr_data = (req_reg.req_type == REQ_REPLACE) ? req_reg.new_value
                        : (g_rd_data ^ bit_mask(req_reg.flip_bit));
        end
        else if (cmd.undo_wr)
        begin
            g_wr_addr = e_addr;
            g_wr_data = e_invert ? (g_rd_data ^ bit_mask(e_info[2:0])) : e_info;
        end
    end

    always_comb
    begin
        j_wr_en   = cmd.modify;
        j_wr_data = (req_reg.req_type == REQ_REPLACE) ? {1'b0, req_addr, g_rd_data}
                    : {1'b1, req_addr, {5'b0, req_reg.flip_bit}};
    end

    gmsu_ram #(
        .WIDTH(8),
        .DEPTH(GENE_COUNT)
    ) u_gene_ram (
        .clk    (clk),
        .wr_en  (g_wr_en),
        .wr_addr(g_wr_addr),
        .wr_data(g_wr_data),
        .rd_en  (g_rd_en),
        .rd_addr(g_rd_addr),
        .rd_data(g_rd_data)
    );

    gmsu_ram #(
        .WIDTH(JE_W),
        .DEPTH(JOURNAL_DEPTH)
    ) u_journal_ram (
        .clk    (clk),
        .wr_en  (j_wr_en),
        .wr_addr(count_reg[JA_W-1:0]),
        .wr_data(j_wr_data),
        .rd_en  (cmd.undo_jrd),
        .rd_addr(k_m1[JA_W-1:0]),
        .rd_data(j_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_size_reg <= ACTIVE_SIZE_RST;
            count_reg       <= '0;
            k_reg           <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                active_size_reg <= cfg_wr_data;
            end
            // a new batch drops the journal only when the request is in range
            if (cmd.accept && is_mutate && in_range && in_item.start_batch)
            begin
                count_reg <= '0;
            end
            else if (cmd.modify)
            begin
                count_reg <= count_reg + JC_W'(1);
            end
            if (cmd.accept)
            begin
                k_reg <= count_reg;
            end
            else if (cmd.undo_jrd)
            begin
                k_reg <= k_m1;
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg     <= in_item;
            status_reg  <= status_in;
            rd_flag_reg <= (stat.act == ACT_READ);
        end
        if (cmd.push)
        begin
            out_item_reg.read_value     <= rd_flag_reg ? g_rd_data : 8'd0;
            out_item_reg.status         <= status_reg;
            out_item_reg.journal_length <= 5'(count_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ----- rtl/gene_mutation_store_with_undo_unit.sv -----
// Top level of the gene mutation store with batch undo.
// Depends on gmsu_pkg, gmsu_ctrl, gmsu_dpath (and through it gmsu_ram).
// Usage:
//   Input channel (in_valid / in_stall / in_item) carries one request item:
//   load, replace, invert bit, undo batch or read. Every request gives one
//   result item on the output channel (out_valid / out_stall / out_item).
//   cfg_wr_en / cfg_wr_data write active_size; write it only while idle.
// Steps, paced by the genome RAM's registered read, from accepting a request
// to loading the output register:
//   load, read, undo of an empty journal, rejected or unknown requests: finish.
//   replace, invert: read old byte, write byte and journal entry, finish.
//   undo: for each of N entries, newest first, fetch entry, fetch byte, write.
//   One request is in flight at a time; the next is accepted at the edge after
//   its result is loaded, even while that result waits.
// Reset clears the journal count, sets active_size to 1024 and empties the
// output register; genome and journal contents stay undefined until written.
// While the receiver stalls, the output item holds, and a finished request
// holds in its last step until the output register frees up.
module gene_mutation_store_with_undo_unit
    import gmsu_pkg::*;
#(
    parameter int GENE_COUNT    = GENE_COUNT_DEF,
    parameter int JOURNAL_DEPTH = JOURNAL_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer: one request at a time through its RAM steps
    gmsu_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .stat    (stat),
        .cmd     (cmd)
    );

    // storage, checks and output register
    gmsu_dpath #(
        .GENE_COUNT   (GENE_COUNT),
        .JOURNAL_DEPTH(JOURNAL_DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item),
        .cmd        (cmd),
        .stat       (stat)
    );

endmodule

// ----- sim/tb_top.sv -----
// Self-checking bench for gene_mutation_store_with_undo_unit: directed and random request
// items, each result checked field by field against an in-bench genome and journal model.
// Depends on rtl/gmsu_pkg.sv and the unit's RTL under rtl/.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gmsu_pkg::*;

    localparam int          CYCLE_LIMIT     = 400000;
    localparam int          GAP_MAX         = 10;
    localparam int          DRAIN_CYCLES    = 20;
    localparam int          SETTLE_CYCLES   = 2;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          BURST_ITEMS     = 40;
    localparam int          RANDOM_ITEMS    = 460;
    localparam int          RANDOM_PHASES   = 6;
    localparam logic [2:0]  REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  REQ_SPARE_LAST  = 3'd7;
    localparam logic [10:0] SIZE_FIELD_MAX  = 11'd2047;

    // requests that carry an index and so can be rejected as out of range
    localparam logic [2:0] RANGED_REQS [4] = '{REQ_LOAD, REQ_REPLACE, REQ_INVERT, REQ_READ};

    // every input starts at a known value
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [10:0] cfg_wr_data = '0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    in_item_t    in_item     = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    out_item_t   out_item;

    // in-bench copy of the unit's state
    logic [7:0]  genome [GENE_COUNT_DEF];
    bit          loaded [GENE_COUNT_DEF];
    int          loaded_list [$];
    logic        jrnl_invert [JOURNAL_DEPTH_DEF];
    logic [9:0]  jrnl_index [JOURNAL_DEPTH_DEF];
    logic [7:0]  jrnl_info [JOURNAL_DEPTH_DEF];
    int          jrnl_count  = 0;
    logic [10:0] active_size = ACTIVE_SIZE_RST;

    // results still owed by the unit, oldest first
    out_item_t   store_replies [$];

    int   mismatches = 0;
    int   cycles     = 0;
    int   items_sent = 0;
    int   results_seen = 0;
    int   next_gap   = 1;
    int   rx_wait    = 0;
    bit   no_gaps    = 1'b0;
    logic rx_hold    = 1'b0;

    gene_mutation_store_with_undo_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: end the run if the traffic never drains.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic int bytes_in_use();
        return (active_size < GENE_COUNT_DEF) ? int'(active_size) : GENE_COUNT_DEF;
    endfunction

    // Advance the model by one request item and return the result it owes.
    function automatic out_item_t apply_request(input in_item_t rq);
        out_item_t r;
        bit        in_range;
        r        = '0;
        in_range = int'(rq.gene_addr) < bytes_in_use();
        case (rq.req_type)
            REQ_LOAD:
                if (in_range)
                begin
                    genome[rq.gene_addr] = rq.new_value;
                    if (!loaded[rq.gene_addr])
                    begin
                        loaded[rq.gene_addr] = 1'b1;
                        loaded_list.insert(loaded_list.size(), int'(rq.gene_addr));
                    end
                end
                else
                    r.status = ST_RANGE;
            REQ_REPLACE, REQ_INVERT:
                if (!in_range)
                    r.status = ST_RANGE;    // start_batch dropped as well
                else
                begin
                    if (rq.start_batch)
                        jrnl_count = 0;
                    if (jrnl_count >= JOURNAL_DEPTH_DEF)
                        r.status = ST_FULL;
                    else
                    begin
                        jrnl_index[jrnl_count]  = rq.gene_addr;
                        jrnl_invert[jrnl_count] = (rq.req_type == REQ_INVERT);
                        if (rq.req_type == REQ_REPLACE)
                        begin
                            jrnl_info[jrnl_count] = genome[rq.gene_addr];
                            genome[rq.gene_addr]  = rq.new_value;
                        end
                        else
                        begin
                            jrnl_info[jrnl_count] = {5'd0, rq.flip_bit};
                            genome[rq.gene_addr] ^= MSB_MASK >> rq.flip_bit;
                        end
                        jrnl_count++;
                    end
                end
            REQ_UNDO:
                // replay newest first; the journal itself stays as it is
                for (int k = jrnl_count - 1; k >= 0; k--)
                begin
                    if (jrnl_invert[k])
                        genome[jrnl_index[k]] ^= MSB_MASK >> jrnl_info[k][2:0];
                    else
                        genome[jrnl_index[k]] = jrnl_info[k];
                end
            REQ_READ:
                if (in_range)
                    r.read_value = genome[rq.gene_addr];
                else
                    r.status = ST_RANGE;
            default:
                ;
        endcase
        r.journal_length = 5'(jrnl_count);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic in_item_t make_item(input logic [2:0] req, input logic [9:0] idx,
                                           input logic [7:0] val, input logic [2:0] bitpos,
                                           input logic start);
        in_item_t it;
        it.req_type    = req;
        it.gene_addr   = idx;
        it.new_value   = val;
        it.flip_bit    = bitpos;
        it.start_batch = start;
        return it;
    endfunction

    // Pick an in-range byte that has been loaded; reads and mutations touch only those.
    function automatic bit pick_loaded(output logic [9:0] idx);
        int cand [$];
        idx = '0;
        foreach (loaded_list[i])
            if (loaded_list[i] < bytes_in_use())
                cand.insert(cand.size(), loaded_list[i]);
        if (cand.size() == 0)
            return 1'b0;
        idx = 10'(cand[$urandom_range(0, cand.size() - 1)]);
        return 1'b1;
    endfunction

    function automatic in_item_t load_request();
        int top;
        top = (bytes_in_use() > 0) ? bytes_in_use() - 1 : GENE_COUNT_DEF - 1;
        return make_item(REQ_LOAD, 10'($urandom_range(0, top)), 8'($urandom),
                         3'($urandom), 1'($urandom));
    endfunction

    function automatic in_item_t mutation_request(input logic start);
        logic [9:0] idx;
        if (!pick_loaded(idx))
            return load_request();
        return make_item(($urandom_range(0, 1) != 0) ? REQ_REPLACE : REQ_INVERT, idx,
                         8'($urandom), 3'($urandom), start);
    endfunction

    function automatic in_item_t read_request();
        logic [9:0] idx;
        if (!pick_loaded(idx))
            return load_request();
        return make_item(REQ_READ, idx, 8'($urandom), 3'($urandom), 1'($urandom));
    endfunction

    function automatic in_item_t undo_request();
        return make_item(REQ_UNDO, 10'($urandom), 8'($urandom), 3'($urandom),
                         1'($urandom));
    endfunction

    // Index at or above the bytes in use; falls back to a read when none exists.
    function automatic in_item_t range_error_request();
        if (bytes_in_use() >= GENE_COUNT_DEF)
            return read_request();
        return make_item(RANGED_REQS[$urandom_range(0, 3)],
                         10'($urandom_range(bytes_in_use(), GENE_COUNT_DEF - 1)),
                         8'($urandom), 3'($urandom), 1'($urandom));
    endfunction

    // One item of background traffic, weighted toward reads and mutations.
    function automatic in_item_t random_request();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return load_request();
        if (roll < 62)
            return mutation_request($urandom_range(0, 5) == 0);
        if (roll < 70)
            return undo_request();
        if (roll < 87)
            return read_request();
        if (roll < 95)
            return range_error_request();
        return make_item(3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST)), 10'($urandom),
                         8'($urandom), 3'($urandom), 1'($urandom));
    endfunction

    function automatic int draw_wait();
        return no_gaps ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------

    // Offer one item, hold it until accepted, then log what it must produce.
    // Valid stays high only when the next item follows at once.
    task automatic send_item(input in_item_t it);
        out_item_t want;
        repeat (next_gap) @(posedge clk);
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        want = apply_request(it);
        store_replies.insert(store_replies.size(), want);
        items_sent++;
        next_gap = draw_wait();
        if (next_gap > 0)
            in_valid <= 1'b0;
    endtask

    // Call in the same step as the last acceptance so no item is offered twice.
    task automatic drop_valid();
        if (next_gap == 0)
        begin
            in_valid <= 1'b0;
            next_gap = 1;
        end
    endtask

    task automatic wait_drained();
        drop_valid();
        while (store_replies.size() != 0)
            @(posedge clk);
    endtask

    // Write active_size only with nothing in flight.
    task automatic write_active_size(input logic [10:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        active_size = value;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] result %0d: %s mismatch, got 0x%0h, expected 0x%0h",
                 $time, results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        results_seen++;
        if (store_replies.size() == 0)
        begin
            report_mismatch("unrequested item", int'(got), 0);
            return;
        end
        want = store_replies.pop_front();
        if (got.read_value !== want.read_value)
            report_mismatch("read_value", int'(got.read_value), int'(want.read_value));
        if (got.status !== want.status)
            report_mismatch("status", int'(got.status), int'(want.status));
        if (got.journal_length !== want.journal_length)
            report_mismatch("journal_length", int'(got.journal_length),
                            int'(want.journal_length));
    endtask

    // Receiver: take a result, then stall for a drawn number of cycles.
    // rx_hold adds a long hold-off on top of that.
    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && !out_stall)
        begin
            check_result(out_item);
            rx_wait = draw_wait();
        end
        else if (rx_wait > 0)
            rx_wait--;
        out_stall <= rx_hold || (rx_wait > 0);
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every request type, field extremes, MSB and LSB flips, an empty-journal undo, then undo twice.
    task automatic test_basic_ops();
        send_item(make_item(REQ_UNDO,    10'd0,    8'h00, 3'd0, 1'b0));  // empty journal
        send_item(make_item(REQ_LOAD,    10'd0,    8'h00, 3'd7, 1'b1));  // start ignored
        send_item(make_item(REQ_LOAD,    10'd1023, 8'hFF, 3'd0, 1'b0));
        send_item(make_item(REQ_READ,    10'd1023, 8'hFF, 3'd7, 1'b1));
        send_item(make_item(REQ_REPLACE, 10'd1023, 8'h00, 3'd0, 1'b1));
        send_item(make_item(REQ_INVERT,  10'd0,    8'hFF, 3'd0, 1'b0));  // MSB
        send_item(make_item(REQ_INVERT,  10'd0,    8'h00, 3'd7, 1'b0));  // LSB
        send_item(make_item(REQ_READ,    10'd0,    8'h00, 3'd0, 1'b0));
        send_item(make_item(REQ_UNDO,    10'd1023, 8'hFF, 3'd7, 1'b1));
        send_item(make_item(REQ_READ,    10'd1023, 8'h00, 3'd0, 1'b0));
        send_item(make_item(REQ_READ,    10'd0,    8'h00, 3'd0, 1'b0));
        // second undo: flips the logged bits again, rewrites the old byte
        send_item(make_item(REQ_UNDO,    10'd0,    8'h00, 3'd0, 1'b0));
        send_item(make_item(REQ_READ,    10'd0,    8'h00, 3'd0, 1'b0));
        send_item(make_item(REQ_SPARE_LAST, 10'h3FF, 8'hFF, 3'd7, 1'b1));
    endtask

    // Fill the journal, bounce one mutation off it, then restart the batch.
    task automatic test_journal_full();
        while (jrnl_count < JOURNAL_DEPTH_DEF)
            send_item(make_item((jrnl_count % 2 != 0) ? REQ_REPLACE : REQ_INVERT, 10'd1023,
                                8'($urandom), 3'(jrnl_count), 1'b0));
        send_item(make_item(REQ_REPLACE, 10'd0, 8'h5A, 3'd0, 1'b0));
        send_item(make_item(REQ_INVERT, 10'd0, 8'h00, 3'd3, 1'b1));
        send_item(make_item(REQ_UNDO, 10'd0, 8'h00, 3'd0, 1'b0));
    endtask

    // Smallest, zero and oversized active_size.
    task automatic test_size_limits();
        write_active_size(11'd1);
        send_item(make_item(REQ_READ,    10'd0,    8'h00, 3'd0, 1'b0));
        send_item(make_item(REQ_READ,    10'd1,    8'h00, 3'd0, 1'b0));
        send_item(make_item(REQ_LOAD,    10'd1,    8'h77, 3'd0, 1'b1));
        send_item(make_item(REQ_REPLACE, 10'd1023, 8'h11, 3'd0, 1'b1));  // journal kept
        send_item(make_item(REQ_INVERT,  10'd0,    8'h00, 3'd5, 1'b0));
        write_active_size(11'd0);
        send_item(make_item(REQ_READ,    10'd0,    8'h00, 3'd0, 1'b0));
        send_item(make_item(REQ_LOAD,    10'd0,    8'h33, 3'd0, 1'b0));
        // undo still reaches the logged bytes with every index out of range
        send_item(make_item(REQ_UNDO,    10'd0,    8'h00, 3'd0, 1'b0));
        write_active_size(SIZE_FIELD_MAX);
        send_item(make_item(REQ_READ,    10'd1023, 8'h00, 3'd0, 1'b0));
        send_item(make_item(REQ_LOAD,    10'd1023, 8'hC3, 3'd0, 1'b0));
        send_item(make_item(REQ_READ,    10'd0,    8'h00, 3'd0, 1'b0));
        write_active_size(ACTIVE_SIZE_RST);
    endtask

    // Hold the receiver off for a long stretch while items keep coming,
    // so the output register fills and the input stalls; then pause the
    // sender until every result is in.
    task automatic test_backpressure();
        no_gaps = 1'b1;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        repeat (BURST_ITEMS) send_item(random_request());
        no_gaps = 1'b0;
        wait_drained();
    endtask

    // A batch: fresh start, a run of mutations (sometimes past a full journal)
    // with reads and noise mixed in, usually an undo or two, then reads.
    task automatic run_batch();
        int len;
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
        begin
            send_item(mutation_request(i == 0));
            if ($urandom_range(0, 3) == 0)
                send_item(($urandom_range(0, 1) != 0) ? read_request() : random_request());
        end
        if ($urandom_range(0, 3) != 0)
        begin
            send_item(undo_request());
            if ($urandom_range(0, 3) == 0)
                send_item(undo_request());
        end
        repeat ($urandom_range(1, 3)) send_item(read_request());
    endtask

    // Random traffic over several active_size settings; every third phase
    // runs with no idling on either side.
    task automatic test_random_mix();
        logic [10:0] sizes [RANDOM_PHASES];
        int          base;
        sizes = '{ACTIVE_SIZE_RST, 11'd300, SIZE_FIELD_MAX, 11'd1,
                  11'($urandom_range(2, GENE_COUNT_DEF - 1)), ACTIVE_SIZE_RST};
        base  = items_sent;
        foreach (sizes[p])
        begin
            write_active_size(sizes[p]);
            no_gaps = (p % 3 == 2);
            while (items_sent - base < (p + 1) * RANDOM_ITEMS / RANDOM_PHASES)
            begin
                if ($urandom_range(0, 4) != 0)
                    run_batch();
                else
                    send_item(random_request());
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_ops();
        test_journal_full();
        test_size_limits();
        test_backpressure();
        test_random_mix();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && store_replies.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
